### sv/smstep_pkg.sv
// Package: shared types, opcodes and status codes of the stack machine step block.
`default_nettype none
package smstep_pkg;

   localparam int unsigned STACK_DEPTH_DEF   = 1024;
   localparam int unsigned PROGRAM_DEPTH_DEF = 1024;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned OPCODE_W = 4;
   localparam int unsigned ADDR_W   = 10;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned STATUS_W = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_NOP    = 4'd0,
      OP_PUSH   = 4'd1,
      OP_DUP    = 4'd2,
      OP_PLUS   = 4'd3,
      OP_MINUS  = 4'd4,
      OP_MULT   = 4'd5,
      OP_DIV    = 4'd6,
      OP_JMP    = 4'd7,
      OP_JMP_IF = 4'd8,
      OP_EQ     = 4'd9,
      OP_HALT   = 4'd10,
      OP_PRINT  = 4'd11
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK              = 3'd0,
      ST_OVERFLOW        = 3'd1,
      ST_UNDERFLOW       = 3'd2,
      ST_ILLEGAL_INST    = 3'd3,
      ST_DIV_ZERO        = 3'd4,
      ST_ILLEGAL_ACCESS  = 3'd5,
      ST_ILLEGAL_OPERAND = 3'd6
   } status_type;

   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_EXEC = 1'b1;

   typedef struct packed {
      logic                action;
      logic [ADDR_W-1:0]   load_address;
      logic [OPCODE_W-1:0] load_opcode;
      logic signed [WORD_W-1:0] load_operand;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                halted;
      logic [COUNT_W-1:0]  next_ip;
      logic [COUNT_W-1:0]  stack_depth;
      logic                print_valid;
      logic signed [WORD_W-1:0] print_value;
   } rsp_type;

   // Control between the sequencer and the shared arithmetic unit.
   typedef struct packed {
      logic start;
      logic is_div;
   } alu_ctl_type;

   typedef struct packed {
      logic done;
      logic busy;
   } alu_sts_type;

endpackage
`default_nettype wire

### sv/smstep_if.sv
// Interfaces: valid/ready channels for request and response transactions.
`default_nettype none
interface smstep_req_if;
   logic                    valid;
   logic                    ready;
   smstep_pkg::req_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface smstep_rsp_if;
   logic                    valid;
   logic                    ready;
   smstep_pkg::rsp_type     payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/smstep_alu.sv
// Shared multi-cycle unit: shift-add multiply and restoring signed divide.
`default_nettype none
module smstep_alu (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire smstep_pkg::alu_ctl_type      ctl,
   input  wire logic [smstep_pkg::WORD_W-1:0] a,
   input  wire logic [smstep_pkg::WORD_W-1:0] b,
   output smstep_pkg::alu_sts_type           sts,
   output logic [smstep_pkg::WORD_W-1:0]     result
);
   localparam int unsigned W  = smstep_pkg::WORD_W;
   localparam int unsigned CW = $clog2(W + 1);

   logic [CW-1:0]  count_ff;
   logic           busy_ff;
   logic           done_ff;
   logic           div_ff;
   logic           neg_ff;
   logic [W-1:0]   acc_ff;   // product or remainder
   logic [W-1:0]   opa_ff;   // multiplicand, or dividend/quotient shift
   logic [W-1:0]   opb_ff;   // multiplier, or divisor magnitude
   logic [W:0]     trial;
   logic [W-1:0]   rem_shift;
   logic [W-1:0]   abs_a;
   logic [W-1:0]   abs_b;

   assign abs_a = a[W-1] ? (~a + 1'b1) : a;
   assign abs_b = b[W-1] ? (~b + 1'b1) : b;
   assign rem_shift = {acc_ff[W-2:0], opa_ff[W-1]};
   assign trial = {1'b0, rem_shift} - {1'b0, opb_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CW'(W);
            div_ff   <= ctl.is_div;
            neg_ff   <= a[W-1] ^ b[W-1];
            acc_ff   <= '0;
            if (ctl.is_div) begin
               opa_ff <= abs_a;
               opb_ff <= abs_b;
            end else begin
               opa_ff <= a;
               opb_ff <= b;
            end
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               // Apply sign to the quotient; wraps for most negative / -1.
               if (div_ff && neg_ff) acc_ff <= ~opa_ff + 1'b1;
               else if (div_ff)      acc_ff <= opa_ff;
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1;
               if (div_ff) begin
                  if (!trial[W]) begin
                     acc_ff <= trial[W-1:0];
                     opa_ff <= {opa_ff[W-2:0], 1'b1};
                  end else begin
                     acc_ff <= rem_shift;
                     opa_ff <= {opa_ff[W-2:0], 1'b0};
                  end
               end else begin
                  if (opb_ff[0]) acc_ff <= acc_ff + opa_ff;
                  opa_ff <= {opa_ff[W-2:0], 1'b0};
                  opb_ff <= {1'b0, opb_ff[W-1:1]};
               end
            end
         end
      end
   end

   assign sts.done = done_ff;
   assign sts.busy = busy_ff;
   assign result   = acc_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start) else $error("alu restarted while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("alu done without work");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("alu done held");
endmodule
`default_nettype wire

### sv/stack_machine_step.sv
// Top level: 64-bit stack machine with program memory and data stack.
//
//  channel | direction | handshake            | payload
//  req     | in        | req.valid/req.ready  | action, load_address, load_opcode, load_operand
//  rsp     | out       | rsp.valid/rsp.ready  | status, halted, next_ip, stack_depth, print_*
//  csr     | in        | csr_write_enable     | program_length (11 bits)
//
// A load steps through accept, program write and response; an instruction steps through
// accept, fetch, two stack reads, execute and response. An execute that finds the machine
// halted or the ip out of range skips the reads and goes straight to the response.
// Multiply and divide run on the shared shift-add/subtract unit; the sequencer waits in S_ALU until it is done.
// Memory reads are registered, so fetch and each stack read take a state of their own.
// Reset (synchronous) clears ip, depth, halt flag and program_length; memories are not cleared.
// One transaction is in flight: req.ready drops until its response is taken, and the
// response is held while rsp.ready is low.
`default_nettype none
module stack_machine_step #(
   parameter int unsigned STACK_DEPTH   = smstep_pkg::STACK_DEPTH_DEF,
   parameter int unsigned PROGRAM_DEPTH = smstep_pkg::PROGRAM_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   smstep_req_if.sink                           req,
   smstep_rsp_if.source                         rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [smstep_pkg::COUNT_W-1:0]  csr_write_data
);
   localparam int unsigned W   = smstep_pkg::WORD_W;
   localparam int unsigned CW  = smstep_pkg::COUNT_W;
   localparam int unsigned OW  = smstep_pkg::OPCODE_W;
   localparam int unsigned PAW = $clog2(PROGRAM_DEPTH);
   localparam int unsigned SAW = $clog2(STACK_DEPTH);
   localparam int unsigned IPW = $clog2(PROGRAM_DEPTH + 1);
   localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_READ1, S_READ2, S_EXEC, S_ALU, S_RESP
   } state_type;

   // Memories.
   logic [OW-1:0] prog_op_mem  [PROGRAM_DEPTH];
   logic [W-1:0]  prog_arg_mem [PROGRAM_DEPTH];
   logic [W-1:0]  stack_mem    [STACK_DEPTH];

   state_type              state_ff;
   smstep_pkg::req_type    req_ff;
   logic [CW-1:0]          plen_ff;
   logic [IPW-1:0]         ip_ff;
   logic [SCW-1:0]         sc_ff;
   logic                   halt_ff;
   logic [OW-1:0]          op_ff;
   logic [W-1:0]           arg_ff;
   logic [W-1:0]           top_ff;    // stack[n-1], or dup source
   logic [W-1:0]           rd_ff;     // registered stack read; stack[n-2] from S_EXEC on
   logic [SAW-1:0]         rd_addr;
   logic                   rd_en;
   smstep_pkg::rsp_type    rsp_ff;
   smstep_pkg::alu_ctl_type alu_ctl;
   smstep_pkg::alu_sts_type alu_sts;
   logic [W-1:0]           alu_res;
   logic                   wr_en;
   logic [SAW-1:0]         wr_addr;
   logic [W-1:0]           wr_data;

   // Effective program limit: min(program_length, PROGRAM_DEPTH).
   logic [IPW:0] limit;
   logic [IPW:0] plen_ext;
   assign plen_ext = (CW > IPW + 1) ? (IPW+1)'(plen_ff > CW'(PROGRAM_DEPTH) ?
                        CW'(PROGRAM_DEPTH) : plen_ff) : (IPW+1)'(plen_ff);
   assign limit = (plen_ext > (IPW+1)'(PROGRAM_DEPTH)) ? (IPW+1)'(PROGRAM_DEPTH) : plen_ext;

   // Jump target: negative or out of range maps to PROGRAM_DEPTH.
   logic [IPW-1:0] target;
   assign target = (arg_ff[W-1] || arg_ff >= W'(PROGRAM_DEPTH)) ?
                   IPW'(PROGRAM_DEPTH) : IPW'(arg_ff);

   logic [SCW-1:0] dup_src;   // n-1-arg, valid when arg < n
   assign dup_src = sc_ff - 1'b1 - SCW'(arg_ff);

   logic [IPW-1:0] ip_next;
   assign ip_next = ip_ff + 1'b1;

   // Program memory: write on load, registered read on fetch.
   always_ff @(posedge clock) begin
      if (state_ff == S_FETCH && req_ff.action == smstep_pkg::ACTION_LOAD
          && 32'(req_ff.load_address) < PROGRAM_DEPTH) begin
         prog_op_mem[PAW'(req_ff.load_address)]  <= req_ff.load_opcode;
         prog_arg_mem[PAW'(req_ff.load_address)] <= req_ff.load_operand;
      end
      op_ff  <= prog_op_mem[PAW'(ip_ff)];
      arg_ff <= prog_arg_mem[PAW'(ip_ff)];
   end

   // Stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) stack_mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= stack_mem[rd_addr];
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = SAW'(sc_ff - 1'b1);
      if (state_ff == S_READ1) begin
         rd_en = 1'b1;
         if (op_ff == smstep_pkg::OP_DUP) rd_addr = SAW'(dup_src);
      end else if (state_ff == S_READ2) begin
         rd_en   = 1'b1;
         rd_addr = SAW'(sc_ff - 2'd2);
      end
   end

   smstep_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctl    (alu_ctl),
      .a      (rd_ff),
      .b      (top_ff),
      .sts    (alu_sts),
      .result (alu_res)
   );

   // Execute step decode: status, write back and next architectural state.
   smstep_pkg::status_type ex_status;
   logic                   ex_done;
   logic [IPW-1:0]         ex_ip;
   logic [SCW-1:0]         ex_sc;
   logic                   ex_halt;
   logic                   ex_pv;
   logic                   a_go;

   always_comb begin
      ex_status = smstep_pkg::ST_OK;
      ex_done   = 1'b1;
      ex_ip     = ip_ff;
      ex_sc     = sc_ff;
      ex_halt   = halt_ff;
      ex_pv     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = SAW'(sc_ff);
      wr_data   = arg_ff;
      a_go      = 1'b0;
      alu_ctl.start  = 1'b0;
      alu_ctl.is_div = (op_ff == smstep_pkg::OP_DIV);
      if (state_ff == S_ALU) begin
         ex_done = alu_sts.done;
         ex_sc   = sc_ff - 1'b1;
         ex_ip   = ip_next;
         wr_en   = alu_sts.done;
         wr_addr = SAW'(sc_ff - 2'd2);
         wr_data = alu_res;
      end else if (state_ff == S_EXEC) begin
         case (op_ff)
            smstep_pkg::OP_NOP: ex_ip = ip_next;
            smstep_pkg::OP_PUSH, smstep_pkg::OP_DUP: begin
               if (sc_ff >= SCW'(STACK_DEPTH)) begin
                  ex_status = smstep_pkg::ST_OVERFLOW;
               end else if (op_ff == smstep_pkg::OP_DUP && !arg_ff[W-1]
                            && arg_ff >= W'(sc_ff)) begin
                  ex_status = smstep_pkg::ST_UNDERFLOW;
               end else if (op_ff == smstep_pkg::OP_DUP && arg_ff[W-1]) begin
                  ex_status = smstep_pkg::ST_ILLEGAL_OPERAND;
               end else begin
                  wr_en   = 1'b1;
                  wr_data = (op_ff == smstep_pkg::OP_DUP) ? top_ff : arg_ff;
                  ex_sc   = sc_ff + 1'b1;
                  ex_ip   = ip_next;
               end
            end
            smstep_pkg::OP_PLUS, smstep_pkg::OP_MINUS, smstep_pkg::OP_MULT,
            smstep_pkg::OP_DIV, smstep_pkg::OP_EQ: begin
               if (sc_ff < SCW'(2)) begin
                  ex_status = smstep_pkg::ST_UNDERFLOW;
               end else if (op_ff == smstep_pkg::OP_DIV && top_ff == '0) begin
                  ex_status = smstep_pkg::ST_DIV_ZERO;
               end else if (op_ff == smstep_pkg::OP_MULT || op_ff == smstep_pkg::OP_DIV) begin
                  ex_done       = 1'b0;
                  a_go          = 1'b1;
                  alu_ctl.start = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = SAW'(sc_ff - 2'd2);
                  if (op_ff == smstep_pkg::OP_PLUS)       wr_data = rd_ff + top_ff;
                  else if (op_ff == smstep_pkg::OP_MINUS) wr_data = rd_ff - top_ff;
                  else wr_data = W'(rd_ff == top_ff);
                  ex_sc = sc_ff - 1'b1;
                  ex_ip = ip_next;
               end
            end
            smstep_pkg::OP_JMP: ex_ip = target;
            smstep_pkg::OP_JMP_IF: begin
               if (sc_ff == '0) begin
                  ex_status = smstep_pkg::ST_UNDERFLOW;
               end else if (top_ff != '0) begin
                  ex_sc = sc_ff - 1'b1;
                  ex_ip = target;
               end else begin
                  ex_ip = ip_next;
               end
            end
            smstep_pkg::OP_HALT: ex_halt = 1'b1;
            smstep_pkg::OP_PRINT: begin
               if (sc_ff == '0) begin
                  ex_status = smstep_pkg::ST_UNDERFLOW;
               end else begin
                  ex_pv = 1'b1;
                  ex_sc = sc_ff - 1'b1;
                  ex_ip = ip_next;
               end
            end
            default: ex_status = smstep_pkg::ST_ILLEGAL_INST;
         endcase
      end
   end

   assign req.ready   = (state_ff == S_IDLE);
   assign rsp.valid   = (state_ff == S_RESP);
   assign rsp.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         plen_ff  <= '0;
         ip_ff    <= '0;
         sc_ff    <= '0;
         halt_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) plen_ff <= csr_write_data;
         case (state_ff)
            S_IDLE: begin
               if (req.valid) begin
                  req_ff   <= req.payload;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               // Load writes memory here; execute checks the halt flag and ip and fetches.
               rsp_ff.status      <= smstep_pkg::ST_OK;
               rsp_ff.halted      <= halt_ff;
               rsp_ff.next_ip     <= CW'(ip_ff);
               rsp_ff.stack_depth <= CW'(sc_ff);
               rsp_ff.print_valid <= 1'b0;
               rsp_ff.print_value <= '0;
               if (req_ff.action == smstep_pkg::ACTION_LOAD || halt_ff) begin
                  state_ff <= S_RESP;
               end else if ({1'b0, ip_ff} >= limit) begin
                  rsp_ff.status <= smstep_pkg::ST_ILLEGAL_ACCESS;
                  state_ff      <= S_RESP;
               end else begin
                  state_ff <= S_READ1;
               end
            end
            S_READ1: state_ff <= S_READ2;   // top (or dup source) read issued
            S_READ2: begin
               top_ff   <= rd_ff;            // second word read issued
               state_ff <= S_EXEC;
            end
            S_EXEC, S_ALU: begin
               if (state_ff == S_EXEC) begin
                  if (op_ff != smstep_pkg::OP_DUP) top_ff <= top_ff;
               end
               if (a_go) begin
                  state_ff <= S_ALU;
               end else if (ex_done) begin
                  if (ex_status == smstep_pkg::ST_OK) begin
                     ip_ff   <= ex_ip;
                     sc_ff   <= ex_sc;
                     halt_ff <= ex_halt;
                     rsp_ff.halted      <= ex_halt;
                     rsp_ff.next_ip     <= CW'(ex_ip);
                     rsp_ff.stack_depth <= CW'(ex_sc);
                     rsp_ff.print_valid <= ex_pv;
                     rsp_ff.print_value <= ex_pv ? top_ff : '0;
                  end
                  rsp_ff.status <= ex_status;
                  state_ff      <= S_RESP;
               end
            end
            S_RESP: begin
               if (rsp.ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      sc_ff <= SCW'(STACK_DEPTH)) else $error("stack depth beyond capacity");
   a_error_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && ex_done && !a_go && ex_status != smstep_pkg::ST_OK)
      |=> $stable(sc_ff) && $stable(ip_ff)) else $error("error changed state");
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      $past(halt_ff) |-> halt_ff) else $error("halt flag cleared");
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp_ff.print_valid |-> rsp_ff.status == smstep_pkg::ST_OK)
      else $error("print with error status");
endmodule
`default_nettype wire
